/* hw/rtl/mwmn_pkg.sv */
// Shared types and constants for the mecanum wheel mixer with speed normalisation.
// Used by mwmn_mix, mwmn_div_cell and mecanum_wheel_mixer_normalize; no dependencies.
`timescale 1ns / 1ps

package mwmn_pkg;

    // Field and datapath widths
    localparam int LANES     = 4;
    localparam int X_W       = 15;                // trans_x / trans_y
    localparam int ROT_IN_W  = 13;                // rotation
    localparam int GAIN_W    = 4;
    localparam int LIM_W     = 15;                // max_wheel_speed
    localparam int TERM_W    = 19;                // X or Y after translation gain
    localparam int ROT_W     = 17;                // rotation after gain or boost
    localparam int SUM_W     = 21;                // one wheel mix, signed
    localparam int MAG_W     = SUM_W - 1;         // magnitude of one wheel mix
    localparam int QUO_W     = LIM_W;             // quotient bits, one per divider cell
    localparam int PROD_W    = MAG_W + LIM_W;     // magnitude times limit
    localparam int REM_W     = MAG_W + 1;         // trial remainder in a cell
    localparam int CFG_IDX_W = 2;

    // Keyboard-mode rotation boost
    localparam int Y_BOOST_THRESHOLD = 5000;
    localparam int ROT_BOOST_HIGH    = 50;
    localparam int ROT_BOOST_LOW     = 5;

    // Reset values of the registers
    localparam logic [GAIN_W-1:0] TRANS_GAIN_RST = 4'd1;
    localparam logic [GAIN_W-1:0] ROT_GAIN_RST   = 4'd1;
    localparam logic [LIM_W-1:0]  MAX_SPEED_RST  = 15'd7500;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 2'd2;

    typedef enum logic {
        OP_REMOTE   = 1'b0,
        OP_KEYBOARD = 1'b1
    } op_t;

    // Mixer output: wheel magnitudes, signs and the scaling decision
    typedef struct packed {
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic [MAG_W-1:0]            maxmag;
        logic                        scale;
    } mix_t;

    // One wheel inside the divider chain: partial remainder and the shift
    // word that gives up dividend bits at the top and takes quotient bits in
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] bits;
    } div_lane_t;

    typedef struct packed {
        logic [MAG_W-1:0]             divisor;
        logic [LANES-1:0]             neg;
        div_lane_t [LANES-1:0]        lane;
    } div_tok_t;

endpackage

/* hw/rtl/mecanum_wheel_mixer_normalize.sv */
// Top level of the mecanum wheel mixer with speed normalisation.
// Instantiates mwmn_mix and a chain of mwmn_div_cell; depends on mwmn_pkg.
`timescale 1ns / 1ps

// Usage
//   Command channel: an item is taken at a rising edge with start high and
//   busy low. busy is never raised, so a command may be given every cycle.
//   Result channel: done is high for exactly one cycle with wheel_a..wheel_d;
//   the receiver cannot hold results off, and none is needed: the pipeline
//   never stops.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Index 0 translation gain, 1 rotation gain, 2 wheel speed
//   limit; other indexes are ignored. Write only while no command is in flight.
//   Pipeline: the item passes through four mixer stages, one multiply stage,
//   fifteen divider cells (one quotient bit each) and the output register.
//   Throughput: one item per cycle; the divider chain is fully pipelined.
//   Reset: clears the in-flight marks (done low) and loads the register
//   defaults: gains of one and a limit of 7500.

module mecanum_wheel_mixer_normalize #(
    parameter int WHEEL_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   opcode,
    input  logic signed [mwmn_pkg::X_W-1:0]        trans_x,
    input  logic signed [mwmn_pkg::X_W-1:0]        trans_y,
    input  logic signed [mwmn_pkg::ROT_IN_W-1:0]   rotation,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mwmn_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mwmn_pkg::LIM_W-1:0]             cfg_data,
    output logic                                   done,
    output logic signed [WHEEL_WIDTH-1:0]          wheel_a,
    output logic signed [WHEEL_WIDTH-1:0]          wheel_b,
    output logic signed [WHEEL_WIDTH-1:0]          wheel_c,
    output logic signed [WHEEL_WIDTH-1:0]          wheel_d
);
    import mwmn_pkg::*;

    localparam int unsigned SPEED_CAP = (1 << (WHEEL_WIDTH - 1)) - 1;

    // Configuration registers
    logic [GAIN_W-1:0]  trans_gain_reg, rot_gain_reg;
    logic [LIM_W-1:0]   max_speed_reg;
    logic [LIM_W-1:0]   lim;

    // Mixer to multiply stage
    logic               mix_valid;
    mix_t               mix;

    // Multiply stage
    logic               mul_valid_reg;
    div_tok_t           mul_tok_reg, mul_tok_next;
    logic [LIM_W-1:0]   factor;
    logic [PROD_W-1:0]  prod [LANES];

    // Divider chain
    logic [QUO_W:0]     chain_valid;
    div_tok_t           chain_tok [QUO_W+1];

    // Output register
    logic               done_reg;
    logic signed [WHEEL_WIDTH-1:0] wheel_reg  [LANES];
    logic signed [WHEEL_WIDTH-1:0] wheel_next [LANES];
    logic [WHEEL_WIDTH-1:0]        quo_ext    [LANES];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trans_gain_reg <= TRANS_GAIN_RST;
            rot_gain_reg   <= ROT_GAIN_RST;
            max_speed_reg  <= MAX_SPEED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TRANS_GAIN: trans_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_ROT_GAIN:   rot_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_MAX_SPEED:  max_speed_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Cap the limit so every wheel fits the output width
    always_comb
    begin
        if (32'(max_speed_reg) > 32'(SPEED_CAP))
            lim = LIM_W'(SPEED_CAP);
        else
            lim = max_speed_reg;
    end

    mwmn_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .opcode     (opcode),
        .trans_x    (trans_x),
        .trans_y    (trans_y),
        .rotation   (rotation),
        .trans_gain (trans_gain_reg),
        .rot_gain   (rot_gain_reg),
        .lim        (lim),
        .out_valid  (mix_valid),
        .out_mix    (mix)
    );

    // Form magnitude times limit over the largest magnitude; an item that
    // needs no scaling goes through the chain as magnitude over one
    always_comb
    begin
        factor               = mix.scale ? lim : LIM_W'(1);
        mul_tok_next.divisor = mix.scale ? mix.maxmag : MAG_W'(1);
        mul_tok_next.neg     = mix.neg;
        for (int i = 0; i < LANES; i++)
        begin
            prod[i] = PROD_W'(mix.mag[i]) * PROD_W'(factor);
            mul_tok_next.lane[i].rem  = prod[i][PROD_W-1:QUO_W];
            mul_tok_next.lane[i].bits = prod[i][QUO_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_valid_reg <= 1'b0;
        else
            mul_valid_reg <= mix_valid;
    end

    always_ff @(posedge clk)
    begin
        mul_tok_reg <= mul_tok_next;
    end

    assign chain_valid[0] = mul_valid_reg;
    assign chain_tok[0]   = mul_tok_reg;

    // One cell per quotient bit
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_cell
        mwmn_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_tok    (chain_tok[k]),
            .out_valid (chain_valid[k+1]),
            .out_tok   (chain_tok[k+1])
        );
    end

    // Restore the signs
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            quo_ext[i]    = WHEEL_WIDTH'(chain_tok[QUO_W].lane[i].bits);
            wheel_next[i] = chain_tok[QUO_W].neg[i] ? $signed(-quo_ext[i])
                                                    : $signed(quo_ext[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chain_valid[QUO_W];
    end

    always_ff @(posedge clk)
    begin
        wheel_reg <= wheel_next;
    end

    assign done    = done_reg;
    assign wheel_a = wheel_reg[0];
    assign wheel_b = wheel_reg[1];
    assign wheel_c = wheel_reg[2];
    assign wheel_d = wheel_reg[3];

    // Every quotient leaving the chain is within the limit
    a_quo_limit: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[QUO_W] |-> (chain_tok[QUO_W].lane[0].bits <= lim) &&
                               (chain_tok[QUO_W].lane[1].bits <= lim) &&
                               (chain_tok[QUO_W].lane[2].bits <= lim) &&
                               (chain_tok[QUO_W].lane[3].bits <= lim))
        else $error("wheel speed above limit");

    // A scaled item starts with a divisor above the limit
    a_scale_div: assert property (@(posedge clk) disable iff (!rst_n)
        (mix_valid && mix.scale) |=> (mul_tok_reg.divisor > MAG_W'($past(lim))))
        else $error("scaling divisor not above limit");

endmodule

/* hw/rtl/mwmn_mix.sv */
// Front end of the mixer: gains, keyboard rotation boost, wheel sums,
// magnitudes, largest magnitude and the scaling decision. Depends on mwmn_pkg.
`timescale 1ns / 1ps

module mwmn_mix (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           opcode,
    input  logic signed [mwmn_pkg::X_W-1:0]      trans_x,
    input  logic signed [mwmn_pkg::X_W-1:0]      trans_y,
    input  logic signed [mwmn_pkg::ROT_IN_W-1:0] rotation,
    input  logic [mwmn_pkg::GAIN_W-1:0]    trans_gain,
    input  logic [mwmn_pkg::GAIN_W-1:0]    rot_gain,
    input  logic [mwmn_pkg::LIM_W-1:0]     lim,
    output logic                           out_valid,
    output mwmn_pkg::mix_t                 out_mix
);
    import mwmn_pkg::*;

    // Stage 1: gains
    logic                      s1_valid_reg;
    logic signed [TERM_W-1:0]  s1_x_reg, s1_y_reg, s1_x_next, s1_y_next;
    logic signed [ROT_W-1:0]   s1_r_reg, s1_r_next;
    logic                      s1_kbd_reg, s1_ybig_reg, s1_kbd_next, s1_ybig_next;
    logic [GAIN_W-1:0]         xy_gain;
    logic signed [X_W+GAIN_W:0]      x_prod, y_prod;
    logic signed [ROT_IN_W+GAIN_W:0] r_prod;

    // Stage 2: boost and mix
    logic                      s2_valid_reg;
    logic signed [SUM_W-1:0]   s2_w_reg [LANES];
    logic signed [SUM_W-1:0]   s2_w_next [LANES];
    logic signed [ROT_W-1:0]   r_eff;
    logic signed [SUM_W-1:0]   xs, ys, rs;
    logic                      boost;

    // Stage 3: magnitudes
    logic                      s3_valid_reg;
    logic [LANES-1:0][MAG_W-1:0] s3_mag_reg, s3_mag_next;
    logic [LANES-1:0]          s3_neg_reg, s3_neg_next;

    // Stage 4: largest magnitude
    logic                      s4_valid_reg;
    mix_t                      s4_mix_reg, s4_mix_next;
    logic [MAG_W-1:0]          max01, max23, max_all;

    // Apply gains; keyboard mode leaves X and Y as they are
    always_comb
    begin
        xy_gain      = (opcode == OP_KEYBOARD) ? GAIN_W'(1) : trans_gain;
        x_prod       = trans_x * $signed({1'b0, xy_gain});
        y_prod       = trans_y * $signed({1'b0, xy_gain});
        r_prod       = rotation * $signed({1'b0, rot_gain});
        s1_x_next    = TERM_W'(x_prod);
        s1_y_next    = TERM_W'(y_prod);
        s1_r_next    = ROT_W'(r_prod);
        s1_kbd_next  = (opcode == OP_KEYBOARD);
        s1_ybig_next = (trans_y > X_W'(Y_BOOST_THRESHOLD)) ||
                       (trans_y < -X_W'(Y_BOOST_THRESHOLD));
    end

    // Boost a small rotation under a large Y in keyboard mode, then mix
    always_comb
    begin
        boost = s1_kbd_reg && s1_ybig_reg &&
                (((s1_r_reg > ROT_W'(ROT_BOOST_LOW)) && (s1_r_reg < ROT_W'(ROT_BOOST_HIGH))) ||
                 ((s1_r_reg < -ROT_W'(ROT_BOOST_LOW)) && (s1_r_reg > -ROT_W'(ROT_BOOST_HIGH))));
        r_eff = boost ? ((s1_r_reg <<< 3) + (s1_r_reg <<< 1)) : s1_r_reg;
        xs    = SUM_W'(s1_x_reg);
        ys    = SUM_W'(s1_y_reg);
        rs    = SUM_W'(r_eff);
        s2_w_next[0] =  xs + ys + rs;
        s2_w_next[1] =  xs - ys + rs;
        s2_w_next[2] = -xs - ys + rs;
        s2_w_next[3] = -xs + ys + rs;
    end

    // Split each mix into sign and magnitude
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            s3_neg_next[i] = s2_w_reg[i][SUM_W-1];
            s3_mag_next[i] = s2_w_reg[i][SUM_W-1] ? MAG_W'(-s2_w_reg[i])
                                                  : MAG_W'(s2_w_reg[i]);
        end
    end

    // Find the largest magnitude and decide whether to scale
    always_comb
    begin
        max01   = (s3_mag_reg[0] > s3_mag_reg[1]) ? s3_mag_reg[0] : s3_mag_reg[1];
        max23   = (s3_mag_reg[2] > s3_mag_reg[3]) ? s3_mag_reg[2] : s3_mag_reg[3];
        max_all = (max01 > max23) ? max01 : max23;
        s4_mix_next.neg    = s3_neg_reg;
        s4_mix_next.mag    = s3_mag_reg;
        s4_mix_next.maxmag = max_all;
        s4_mix_next.scale  = (max_all > MAG_W'(lim));
    end

    // Advance the valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        s1_x_reg    <= s1_x_next;
        s1_y_reg    <= s1_y_next;
        s1_r_reg    <= s1_r_next;
        s1_kbd_reg  <= s1_kbd_next;
        s1_ybig_reg <= s1_ybig_next;
        s2_w_reg    <= s2_w_next;
        s3_mag_reg  <= s3_mag_next;
        s3_neg_reg  <= s3_neg_next;
        s4_mix_reg  <= s4_mix_next;
    end

    assign out_valid = s4_valid_reg;
    assign out_mix   = s4_mix_reg;

    // The largest magnitude bounds every wheel
    a_max_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (s4_mix_reg.maxmag >= s4_mix_reg.mag[0]) &&
                         (s4_mix_reg.maxmag >= s4_mix_reg.mag[1]) &&
                         (s4_mix_reg.maxmag >= s4_mix_reg.mag[2]) &&
                         (s4_mix_reg.maxmag >= s4_mix_reg.mag[3]))
        else $error("largest magnitude below a wheel magnitude");

    // The largest magnitude is one of the wheels
    a_max_member: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (s4_mix_reg.maxmag == s4_mix_reg.mag[0]) ||
                         (s4_mix_reg.maxmag == s4_mix_reg.mag[1]) ||
                         (s4_mix_reg.maxmag == s4_mix_reg.mag[2]) ||
                         (s4_mix_reg.maxmag == s4_mix_reg.mag[3]))
        else $error("largest magnitude matches no wheel");

endmodule

/* hw/rtl/mwmn_div_cell.sv */
// One cell of the divider chain: takes one quotient bit for all four wheels
// against a shared divisor and hands the item on. Depends on mwmn_pkg.
`timescale 1ns / 1ps

module mwmn_div_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  mwmn_pkg::div_tok_t   in_tok,
    output logic                 out_valid,
    output mwmn_pkg::div_tok_t   out_tok
);
    import mwmn_pkg::*;

    logic                valid_reg;
    div_tok_t            tok_reg, tok_next;
    logic [REM_W-1:0]    trial [LANES];
    logic [REM_W-1:0]    diff  [LANES];
    logic [LANES-1:0]    ge;

    // Bring down the next dividend bit and subtract where the divisor fits
    always_comb
    begin
        tok_next = in_tok;
        for (int i = 0; i < LANES; i++)
        begin
            trial[i] = {in_tok.lane[i].rem, in_tok.lane[i].bits[QUO_W-1]};
            diff[i]  = trial[i] - {1'b0, in_tok.divisor};
            ge[i]    = (trial[i] >= {1'b0, in_tok.divisor});
            tok_next.lane[i].rem  = ge[i] ? diff[i][MAG_W-1:0] : trial[i][MAG_W-1:0];
            tok_next.lane[i].bits = {in_tok.lane[i].bits[QUO_W-2:0], ge[i]};
        end
    end

    // Hold the valid mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Advance the item
    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

    // Partial remainders stay below the divisor
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (tok_reg.lane[0].rem < tok_reg.divisor) &&
                      (tok_reg.lane[1].rem < tok_reg.divisor) &&
                      (tok_reg.lane[2].rem < tok_reg.divisor) &&
                      (tok_reg.lane[3].rem < tok_reg.divisor))
        else $error("partial remainder not below divisor");

    // A live item never carries a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (tok_reg.divisor != '0))
        else $error("zero divisor in divider chain");

endmodule
